// ===== sv/bracketed_paste_control_filter_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bracketed paste control filter
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BRACKETED_PASTE_CONTROL_FILTER_TOP_ASSERT_SVH
`define BRACKETED_PASTE_CONTROL_FILTER_TOP_ASSERT_SVH

// Same-cycle implication.
`define BPCF_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BPCF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bpcf_pkg.sv =====
// ----------------------------------------------------------------------------
// bpcf_pkg
// Types, byte codes and marker tables for the bracketed paste control filter.
// ----------------------------------------------------------------------------
package bpcf_pkg;

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = 1;
    localparam int CMDQ_CW    = CMDQ_AW + 1;

    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = 2;
    localparam int OUTQ_CW    = OUTQ_AW + 1;

    localparam int MARKER_LEN = 6;
    localparam int MARKER_IW  = 3;

    localparam int HELD_DEPTH = 3;
    localparam int HELD_IW    = 2;
    localparam int HELD_CW    = 2;

    localparam logic [7:0] BYTE_BEL       = 8'h07;
    localparam logic [7:0] BYTE_TAB       = 8'h09;
    localparam logic [7:0] BYTE_LF        = 8'h0A;
    localparam logic [7:0] BYTE_CR        = 8'h0D;
    localparam logic [7:0] BYTE_ESC       = 8'h1B;
    localparam logic [7:0] BYTE_C0_END    = 8'h20;
    localparam logic [7:0] BYTE_ZERO_CHR  = 8'h30;
    localparam logic [7:0] BYTE_ONE_CHR   = 8'h31;
    localparam logic [7:0] BYTE_TWO_CHR   = 8'h32;
    localparam logic [7:0] BYTE_CSI_LO    = 8'h40;
    localparam logic [7:0] BYTE_DCS_ESC   = 8'h50;
    localparam logic [7:0] BYTE_SOS_ESC   = 8'h58;
    localparam logic [7:0] BYTE_LBRACKET  = 8'h5B;
    localparam logic [7:0] BYTE_BACKSLASH = 8'h5C;
    localparam logic [7:0] BYTE_RBRACKET  = 8'h5D;
    localparam logic [7:0] BYTE_PM_ESC    = 8'h5E;
    localparam logic [7:0] BYTE_APC_ESC   = 8'h5F;
    localparam logic [7:0] BYTE_CSI_HI    = 8'h7E;
    localparam logic [7:0] BYTE_TILDE     = 8'h7E;
    localparam logic [7:0] BYTE_DEL       = 8'h7F;
    localparam logic [7:0] BYTE_C1_LO     = 8'h80;
    localparam logic [7:0] BYTE_DCS_C1    = 8'h90;
    localparam logic [7:0] BYTE_SOS_C1    = 8'h98;
    localparam logic [7:0] BYTE_CSI_C1    = 8'h9B;
    localparam logic [7:0] BYTE_ST_C1     = 8'h9C;
    localparam logic [7:0] BYTE_OSC_C1    = 8'h9D;
    localparam logic [7:0] BYTE_PM_C1     = 8'h9E;
    localparam logic [7:0] BYTE_APC_C1    = 8'h9F;
    localparam logic [7:0] BYTE_C1_END    = 8'hA0;
    localparam logic [7:0] UTF8_CONT_MASK = 8'hC0;
    localparam logic [7:0] UTF8_CONT_TAG  = 8'h80;
    localparam logic [7:0] UTF8_LEAD_LO   = 8'hC2;
    localparam logic [7:0] UTF8_LEAD2_HI  = 8'hDF;
    localparam logic [7:0] UTF8_LEAD3_HI  = 8'hEF;
    localparam logic [7:0] UTF8_LEAD_HI   = 8'hF4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       eot;
        logic       bracketed;
        logic       open;
    } cmd_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
        logic       paste_end;
    } res_t;

    // ESC [ 2 0 0 ~ opens, ESC [ 2 0 1 ~ closes
    function automatic logic [7:0] marker_byte(input logic [MARKER_IW-1:0] idx,
                                               input logic closing);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = BYTE_ESC;
            3'd1:    b = BYTE_LBRACKET;
            3'd2:    b = BYTE_TWO_CHR;
            3'd3:    b = BYTE_ZERO_CHR;
            3'd4:    b = closing ? BYTE_ONE_CHR : BYTE_ZERO_CHR;
            3'd5:    b = BYTE_TILDE;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic is_dropped(input logic [7:0] b);
        logic c0;
        c0 = (b < BYTE_C0_END) && (b != BYTE_TAB) && (b != BYTE_LF) && (b != BYTE_CR);
        return c0 || (b == BYTE_DEL) || ((b >= BYTE_C1_LO) && (b < BYTE_C1_END));
    endfunction

    function automatic logic [HELD_CW-1:0] utf8_needed_of(input logic [7:0] b);
        logic [HELD_CW-1:0] n;
        if (b <= UTF8_LEAD2_HI)
            n = 2'd1;
        else if (b <= UTF8_LEAD3_HI)
            n = 2'd2;
        else
            n = 2'd3;
        return n;
    endfunction

endpackage

// ===== sv/bpcf_front.sv =====
// ----------------------------------------------------------------------------
// bpcf_front
// Input side: holds the mode register and paste framing, tags each byte.
// ----------------------------------------------------------------------------
module bpcf_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic            cfg_bracketed_mode,
    input  logic            push,
    input  logic [7:0]      data_byte,
    input  logic            end_of_text,
    input  logic            q_full,
    output logic            cmd_push,
    output bpcf_pkg::cmd_t  cmd
);

    logic bracketed_mode_reg, bracketed_mode_next;
    logic prefix_sent_reg, prefix_sent_next;

    assign cfg_ready = 1'b1;
    assign cmd_push  = push && !q_full;

    always_comb
    begin
        cmd.data_byte = data_byte;
        cmd.eot       = end_of_text;
        cmd.bracketed = prefix_sent_reg || bracketed_mode_reg;
        cmd.open      = !prefix_sent_reg && bracketed_mode_reg;
    end

    always_comb
    begin
        bracketed_mode_next = bracketed_mode_reg;
        prefix_sent_next    = prefix_sent_reg;
        if (cfg_valid)
            bracketed_mode_next = cfg_bracketed_mode;
        // once opened, a paste stays bracketed until its last byte
        if (cmd_push && cmd.bracketed)
            prefix_sent_next = !end_of_text;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bracketed_mode_reg <= 1'b0;
            prefix_sent_reg    <= 1'b0;
        end
        else
        begin
            bracketed_mode_reg <= bracketed_mode_next;
            prefix_sent_reg    <= prefix_sent_next;
        end
    end

endmodule

// ===== sv/bpcf_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// bpcf_cmd_queue
// Short queue of tagged bytes between the front and back ends.
// ----------------------------------------------------------------------------
module bpcf_cmd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr,
    input  bpcf_pkg::cmd_t  wr_cmd,
    output logic            full,
    input  logic            rd,
    output logic            valid,
    output bpcf_pkg::cmd_t  rd_cmd
);

    bpcf_pkg::cmd_t                  mem_reg [bpcf_pkg::CMDQ_DEPTH];
    logic [bpcf_pkg::CMDQ_AW-1:0]    wptr_reg, wptr_next;
    logic [bpcf_pkg::CMDQ_AW-1:0]    rptr_reg, rptr_next;
    logic [bpcf_pkg::CMDQ_CW-1:0]    count_reg, count_next;
    logic                            wr_ok, rd_ok;

    assign full   = (count_reg == bpcf_pkg::CMDQ_CW'(bpcf_pkg::CMDQ_DEPTH));
    assign valid  = (count_reg != '0);
    assign wr_ok  = wr && !full;
    assign rd_ok  = rd && valid;
    assign rd_cmd = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg + bpcf_pkg::CMDQ_AW'(wr_ok);
        rptr_next  = rptr_reg + bpcf_pkg::CMDQ_AW'(rd_ok);
        count_next = count_reg + bpcf_pkg::CMDQ_CW'(wr_ok) - bpcf_pkg::CMDQ_CW'(rd_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_ok)
            mem_reg[wptr_reg] <= wr_cmd;
    end

endmodule

// ===== sv/bpcf_out_fifo.sv =====
// ----------------------------------------------------------------------------
// bpcf_out_fifo
// Result queue; takes up to two results a cycle, presents the oldest.
// ----------------------------------------------------------------------------
`include "bracketed_paste_control_filter_top_assert.svh"

module bpcf_out_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr0,
    input  logic            wr1,
    input  bpcf_pkg::res_t  wdata0,
    input  logic [0:0]      wr1_dummy_unused_n,
    input  bpcf_pkg::res_t  wdata1,
    output logic            room2,
    input  logic            pop,
    output logic            empty,
    output bpcf_pkg::res_t  head
);

    bpcf_pkg::res_t                  mem_reg [bpcf_pkg::OUTQ_DEPTH];
    logic [bpcf_pkg::OUTQ_AW-1:0]    wptr_reg, wptr_next;
    logic [bpcf_pkg::OUTQ_AW-1:0]    rptr_reg, rptr_next;
    logic [bpcf_pkg::OUTQ_CW-1:0]    count_reg, count_next;
    logic                            rd_ok;
    logic                            wr1_ok;

    assign wr1_ok = wr1 && wr1_dummy_unused_n[0];
    assign empty  = (count_reg == '0);
    assign room2  = (count_reg <= bpcf_pkg::OUTQ_CW'(bpcf_pkg::OUTQ_DEPTH - 2));
    assign rd_ok  = pop && !empty;
    assign head   = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg + bpcf_pkg::OUTQ_AW'(wr0) + bpcf_pkg::OUTQ_AW'(wr1_ok);
        rptr_next  = rptr_reg + bpcf_pkg::OUTQ_AW'(rd_ok);
        count_next = count_reg + bpcf_pkg::OUTQ_CW'(wr0) + bpcf_pkg::OUTQ_CW'(wr1_ok)
                     - bpcf_pkg::OUTQ_CW'(rd_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr0)
            mem_reg[wptr_reg] <= wdata0;
        if (wr1_ok)
            mem_reg[wptr_reg + bpcf_pkg::OUTQ_AW'(1)] <= wdata1;
    end

    `BPCF_ASSERT_IMPLIES(a_count_bound, 1'b1, count_reg <= bpcf_pkg::OUTQ_CW'(bpcf_pkg::OUTQ_DEPTH), "result queue count beyond depth")
    `BPCF_ASSERT_IMPLIES(a_wr_order, wr1, wr0, "second write without first")
    `BPCF_ASSERT_IMPLIES(a_no_overflow, wr0, room2, "write into result queue without room")

endmodule

// ===== sv/bpcf_back.sv =====
// ----------------------------------------------------------------------------
// bpcf_back
// Back end: marker sequencer, control-sequence parser and UTF-8 hold/replay;
// works on one item at a time and tags the last result of each item.
// ----------------------------------------------------------------------------
`include "bracketed_paste_control_filter_top_assert.svh"

module bpcf_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  bpcf_pkg::cmd_t  cmd,
    output logic            cmd_pop,
    input  logic            res_room,
    output logic            res_wr0,
    output logic            res_wr1,
    output bpcf_pkg::res_t  res0,
    output bpcf_pkg::res_t  res1
);

    typedef enum logic [2:0] {
        ST_BYTE,
        ST_OPEN,
        ST_FLUSH,
        ST_REPLAY,
        ST_CLOSE
    } seq_t;

    typedef enum logic [2:0] {
        PM_NORMAL,
        PM_ESC,
        PM_CSI,
        PM_STRING,
        PM_STRING_ESC
    } parse_t;

    seq_t                               state_reg, state_next;
    logic [bpcf_pkg::MARKER_IW-1:0]     idx_reg, idx_next;
    logic [bpcf_pkg::HELD_CW-1:0]       rcnt_reg, rcnt_next;
    logic                               replay_b_reg, replay_b_next;
    logic                               opened_reg, opened_next;
    parse_t                             mode_reg, mode_next;
    logic                               bell_reg, bell_next;
    logic [7:0]                         lead_reg, lead_next;
    logic [bpcf_pkg::HELD_CW-1:0]       needed_reg, needed_next;
    logic [bpcf_pkg::HELD_CW-1:0]       cnt_reg, cnt_next;
    logic [7:0]                         held_reg [bpcf_pkg::HELD_DEPTH];
    logic [7:0]                         held_next [bpcf_pkg::HELD_DEPTH];
    logic                               pend_valid_reg, pend_valid_next;
    logic [7:0]                         pend_byte_reg, pend_byte_next;

    parse_t     f_mode;
    logic       f_bell, f_emit, f_hold, f_cont, f_complete, f_fail;
    logic       step, do_filter, post, replay_held, emit, last;
    logic [7:0] emit_byte, fb, held_rd;

    assign step        = cmd_valid && res_room;
    assign replay_held = (state_reg == ST_REPLAY) && (idx_reg[bpcf_pkg::HELD_CW-1:0] < rcnt_reg);

    always_comb
    begin
        held_rd = held_reg[0];
        for (int i = 0; i < bpcf_pkg::HELD_DEPTH; i++)
            if (idx_reg[bpcf_pkg::HELD_IW-1:0] == bpcf_pkg::HELD_IW'(i))
                held_rd = held_reg[i];
    end

    assign fb = replay_held ? held_rd : cmd.data_byte;

    // parser, one byte
    always_comb
    begin
        f_mode     = mode_reg;
        f_bell     = bell_reg;
        f_emit     = 1'b0;
        f_hold     = 1'b0;
        f_cont     = 1'b0;
        f_complete = 1'b0;
        f_fail     = 1'b0;
        unique case (mode_reg)
            PM_NORMAL:
            begin
                if (needed_reg != '0)
                begin
                    if ((fb & bpcf_pkg::UTF8_CONT_MASK) == bpcf_pkg::UTF8_CONT_TAG)
                    begin
                        f_cont     = 1'b1;
                        f_complete = (cnt_reg + bpcf_pkg::HELD_CW'(1)) >= needed_reg;
                    end
                    else
                        f_fail = 1'b1;
                end
                else if (fb >= bpcf_pkg::UTF8_LEAD_LO && fb <= bpcf_pkg::UTF8_LEAD_HI)
                    f_hold = 1'b1;
                else if (fb == bpcf_pkg::BYTE_ESC)
                    f_mode = PM_ESC;
                else if (fb == bpcf_pkg::BYTE_CSI_C1)
                    f_mode = PM_CSI;
                else if (fb == bpcf_pkg::BYTE_OSC_C1)
                begin
                    f_mode = PM_STRING;
                    f_bell = 1'b1;
                end
                else if (fb == bpcf_pkg::BYTE_DCS_C1 || fb == bpcf_pkg::BYTE_SOS_C1 ||
                         fb == bpcf_pkg::BYTE_PM_C1 || fb == bpcf_pkg::BYTE_APC_C1)
                begin
                    f_mode = PM_STRING;
                    f_bell = 1'b0;
                end
                else
                    f_emit = !bpcf_pkg::is_dropped(fb);
            end
            PM_ESC:
            begin
                if (fb == bpcf_pkg::BYTE_LBRACKET)
                    f_mode = PM_CSI;
                else if (fb == bpcf_pkg::BYTE_RBRACKET)
                begin
                    f_mode = PM_STRING;
                    f_bell = 1'b1;
                end
                else if (fb == bpcf_pkg::BYTE_DCS_ESC || fb == bpcf_pkg::BYTE_SOS_ESC ||
                         fb == bpcf_pkg::BYTE_PM_ESC || fb == bpcf_pkg::BYTE_APC_ESC)
                begin
                    f_mode = PM_STRING;
                    f_bell = 1'b0;
                end
                else
                    f_mode = PM_NORMAL;
            end
            PM_CSI:
            begin
                if (fb >= bpcf_pkg::BYTE_CSI_LO && fb <= bpcf_pkg::BYTE_CSI_HI)
                    f_mode = PM_NORMAL;
            end
            PM_STRING:
            begin
                if ((bell_reg && fb == bpcf_pkg::BYTE_BEL) || fb == bpcf_pkg::BYTE_ST_C1)
                    f_mode = PM_NORMAL;
                else if (fb == bpcf_pkg::BYTE_ESC)
                    f_mode = PM_STRING_ESC;
            end
            PM_STRING_ESC:
            begin
                // not a terminator: the byte is seen again as string content
                if (fb == bpcf_pkg::BYTE_BACKSLASH)
                    f_mode = PM_NORMAL;
                else if ((bell_reg && fb == bpcf_pkg::BYTE_BEL) || fb == bpcf_pkg::BYTE_ST_C1)
                    f_mode = PM_NORMAL;
                else if (fb == bpcf_pkg::BYTE_ESC)
                    f_mode = PM_STRING_ESC;
                else
                    f_mode = PM_STRING;
            end
            default:
                f_mode = PM_NORMAL;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        rcnt_next     = rcnt_reg;
        replay_b_next = replay_b_reg;
        opened_next   = opened_reg;
        mode_next     = mode_reg;
        bell_next     = bell_reg;
        lead_next     = lead_reg;
        needed_next   = needed_reg;
        cnt_next      = cnt_reg;
        for (int i = 0; i < bpcf_pkg::HELD_DEPTH; i++)
            held_next[i] = held_reg[i];
        do_filter = 1'b0;
        post      = 1'b0;
        emit      = 1'b0;
        emit_byte = fb;
        last      = 1'b0;

        if (step)
        begin
            unique case (state_reg)
                ST_BYTE:
                begin
                    if (!cmd.bracketed)
                    begin
                        emit      = 1'b1;
                        emit_byte = cmd.data_byte;
                        last      = 1'b1;
                    end
                    else if (cmd.open && !opened_reg)
                    begin
                        emit       = 1'b1;
                        emit_byte  = bpcf_pkg::marker_byte('0, 1'b0);
                        idx_next   = bpcf_pkg::MARKER_IW'(1);
                        state_next = ST_OPEN;
                    end
                    else
                        do_filter = 1'b1;
                end
                ST_OPEN:
                begin
                    emit      = 1'b1;
                    emit_byte = bpcf_pkg::marker_byte(idx_reg, 1'b0);
                    if (idx_reg == bpcf_pkg::MARKER_IW'(bpcf_pkg::MARKER_LEN - 1))
                    begin
                        idx_next    = '0;
                        opened_next = 1'b1;
                        state_next  = ST_BYTE;
                    end
                    else
                        idx_next = idx_reg + bpcf_pkg::MARKER_IW'(1);
                end
                ST_FLUSH:
                begin
                    emit      = 1'b1;
                    emit_byte = held_rd;
                    if ((idx_reg[bpcf_pkg::HELD_CW-1:0] + bpcf_pkg::HELD_CW'(1)) == rcnt_reg)
                        post = 1'b1;
                    else
                        idx_next = idx_reg + bpcf_pkg::MARKER_IW'(1);
                end
                ST_REPLAY:
                begin
                    if (replay_held)
                    begin
                        do_filter = 1'b1;
                        idx_next  = idx_reg + bpcf_pkg::MARKER_IW'(1);
                    end
                    else if (replay_b_reg)
                        do_filter = 1'b1;
                    else
                    begin
                        idx_next   = '0;
                        state_next = ST_CLOSE;
                    end
                end
                ST_CLOSE:
                begin
                    emit      = 1'b1;
                    emit_byte = bpcf_pkg::marker_byte(idx_reg, 1'b1);
                    if (idx_reg == bpcf_pkg::MARKER_IW'(bpcf_pkg::MARKER_LEN - 1))
                    begin
                        last        = 1'b1;
                        idx_next    = '0;
                        state_next  = ST_BYTE;
                        mode_next   = PM_NORMAL;
                        bell_next   = 1'b0;
                        lead_next   = '0;
                        needed_next = '0;
                        cnt_next    = '0;
                    end
                    else
                        idx_next = idx_reg + bpcf_pkg::MARKER_IW'(1);
                end
                default:
                    state_next = ST_BYTE;
            endcase
        end

        if (do_filter)
        begin
            mode_next = f_mode;
            bell_next = f_bell;
            if (f_emit)
            begin
                emit      = 1'b1;
                emit_byte = fb;
            end
            if (f_hold)
            begin
                lead_next   = fb;
                needed_next = bpcf_pkg::utf8_needed_of(fb);
                cnt_next    = '0;
            end
            if (f_cont)
            begin
                for (int i = 0; i < bpcf_pkg::HELD_DEPTH; i++)
                    if (cnt_reg == bpcf_pkg::HELD_CW'(i))
                        held_next[i] = fb;
                cnt_next = cnt_reg + bpcf_pkg::HELD_CW'(1);
            end
            if (f_complete)
            begin
                emit        = 1'b1;
                emit_byte   = lead_reg;
                rcnt_next   = cnt_reg + bpcf_pkg::HELD_CW'(1);
                lead_next   = '0;
                needed_next = '0;
                cnt_next    = '0;
                idx_next    = '0;
                state_next  = ST_FLUSH;
            end
            else if (f_fail)
            begin
                // lead goes out as is, held bytes and this byte are parsed again
                emit          = 1'b1;
                emit_byte     = lead_reg;
                rcnt_next     = cnt_reg;
                replay_b_next = 1'b1;
                lead_next     = '0;
                needed_next   = '0;
                cnt_next      = '0;
                idx_next      = '0;
                state_next    = ST_REPLAY;
            end
            else if (!replay_held)
                post = 1'b1;
        end

        if (post)
        begin
            idx_next = '0;
            if (!cmd.eot)
            begin
                last       = 1'b1;
                state_next = ST_BYTE;
            end
            else if (needed_next != '0)
            begin
                // paste ends with a lead held
                emit          = 1'b1;
                emit_byte     = lead_next;
                rcnt_next     = cnt_next;
                replay_b_next = 1'b0;
                lead_next     = '0;
                needed_next   = '0;
                cnt_next      = '0;
                state_next    = ST_REPLAY;
            end
            else
                state_next = ST_CLOSE;
        end

        if (last)
            opened_next = 1'b0;
    end

    assign cmd_pop = last;

    // one-deep hold so the last result of an item can be tagged
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        res_wr0         = 1'b0;
        res_wr1         = 1'b0;
        res0.out_byte   = pend_byte_reg;
        res0.run_end    = 1'b0;
        res0.paste_end  = 1'b0;
        res1.out_byte   = emit_byte;
        res1.run_end    = 1'b1;
        res1.paste_end  = cmd.eot;
        if (emit && !last)
        begin
            res_wr0         = pend_valid_reg;
            pend_valid_next = 1'b1;
            pend_byte_next  = emit_byte;
        end
        else if (emit && last)
        begin
            pend_valid_next = 1'b0;
            if (pend_valid_reg)
            begin
                res_wr0 = 1'b1;
                res_wr1 = 1'b1;
            end
            else
            begin
                res_wr0        = 1'b1;
                res0.out_byte  = emit_byte;
                res0.run_end   = 1'b1;
                res0.paste_end = cmd.eot;
            end
        end
        else if (last)
        begin
            pend_valid_next = 1'b0;
            res_wr0         = pend_valid_reg;
            res0.run_end    = 1'b1;
            res0.paste_end  = cmd.eot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_BYTE;
            idx_reg        <= '0;
            rcnt_reg       <= '0;
            replay_b_reg   <= 1'b0;
            opened_reg     <= 1'b0;
            mode_reg       <= PM_NORMAL;
            bell_reg       <= 1'b0;
            lead_reg       <= '0;
            needed_reg     <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            rcnt_reg       <= rcnt_next;
            replay_b_reg   <= replay_b_next;
            opened_reg     <= opened_next;
            mode_reg       <= mode_next;
            bell_reg       <= bell_next;
            lead_reg       <= lead_next;
            needed_reg     <= needed_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_byte_reg <= pend_byte_next;
        for (int i = 0; i < bpcf_pkg::HELD_DEPTH; i++)
            held_reg[i] <= held_next[i];
    end

    `BPCF_ASSERT_IMPLIES(a_head_held, state_reg != ST_BYTE, cmd_valid, "item left queue while in flight")
    `BPCF_ASSERT_IMPLIES(a_lead_in_text, needed_reg != '0, mode_reg == PM_NORMAL, "UTF-8 lead held outside normal text")
    `BPCF_ASSERT_IMPLIES(a_marker_idx, state_reg == ST_OPEN || state_reg == ST_CLOSE, idx_reg < bpcf_pkg::MARKER_IW'(bpcf_pkg::MARKER_LEN), "marker index out of range")
    `BPCF_ASSERT_IMPLIES(a_no_stale_pend, state_reg == ST_BYTE && !opened_reg, !pend_valid_reg, "result left over from previous item")

endmodule

// ===== sv/bracketed_paste_control_filter_top.sv =====
// ----------------------------------------------------------------------------
// bracketed_paste_control_filter_top
// Bracketed paste control filter: wraps a paste in ESC[200~ / ESC[201~ and
// strips terminal control content from it.
// ----------------------------------------------------------------------------
// The back end works on one input byte at a time and waits whenever the
// result queue has fewer than two free entries. In pass-through mode and for
// plain text each byte gives one result. The first byte of a bracketed paste
// is preceded by the opening marker and the last byte is followed by the
// closing one. A complete UTF-8 sequence goes out as the lead and then its
// continuation bytes; a broken sequence sends the lead as is and parses the
// held bytes and the breaking byte again. A paste that ends with a lead held
// sends the lead with the last byte, then parses the held bytes again before
// the closing marker. A two-entry command queue sits between the input and
// the parser, a four-entry result queue on the output side. bracketed_mode
// is written through the cfg channel, always ready.
module bracketed_paste_control_filter_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_bracketed_mode,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       end_of_text,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       run_end,
    output logic       paste_end
);

    bpcf_pkg::cmd_t in_cmd, head_cmd;
    bpcf_pkg::res_t res0, res1, head_res;
    logic           cmd_push, cmd_pop, cmd_valid;
    logic           res_room, res_wr0, res_wr1;

    bpcf_front u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_bracketed_mode (cfg_bracketed_mode),
        .push               (push),
        .data_byte          (data_byte),
        .end_of_text        (end_of_text),
        .q_full             (full),
        .cmd_push           (cmd_push),
        .cmd                (in_cmd)
    );

    bpcf_cmd_queue u_cmd_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (cmd_push),
        .wr_cmd (in_cmd),
        .full   (full),
        .rd     (cmd_pop),
        .valid  (cmd_valid),
        .rd_cmd (head_cmd)
    );

    bpcf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (head_cmd),
        .cmd_pop   (cmd_pop),
        .res_room  (res_room),
        .res_wr0   (res_wr0),
        .res_wr1   (res_wr1),
        .res0      (res0),
        .res1      (res1)
    );

    bpcf_out_fifo u_out_fifo (
        .clk                (clk),
        .rst_n              (rst_n),
        .wr0                (res_wr0),
        .wr1                (res_wr1),
        .wdata0             (res0),
        .wr1_dummy_unused_n (1'b1),
        .wdata1             (res1),
        .room2              (res_room),
        .pop                (pop),
        .empty              (empty),
        .head               (head_res)
    );

    assign out_byte  = head_res.out_byte;
    assign run_end   = head_res.run_end;
    assign paste_end = head_res.paste_end;

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// Testbench for bracketed_paste_control_filter_top
// Drives paste bytes through the push/full queue interface and checks every
// popped result against an in-bench filter model: marker wrapping, control
// sequence stripping, UTF-8 hold and replay, pass-through mode and the
// run_end/paste_end flags. Idle gaps on both sides and a long receiver
// hold-off exercise the internal queues.
// ----------------------------------------------------------------------------
module testbench;
    import bpcf_pkg::*;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int DRAIN_CYCLES  = 24;
    localparam int HOLD_CYCLES   = 200;
    localparam int MAX_RUN       = 13;
    localparam int MAX_PRINTS    = 20;

    typedef enum logic [2:0] {
        SCAN_TEXT,
        SCAN_ESC,
        SCAN_CSI,
        SCAN_STRING,
        SCAN_STRING_ESC
    } scan_state_t;

    localparam logic [7:0] STR_INTRO_C1  [4] = '{BYTE_DCS_C1, BYTE_SOS_C1, BYTE_PM_C1,
                                                 BYTE_APC_C1};
    localparam logic [7:0] STR_INTRO_ESC [4] = '{BYTE_DCS_ESC, BYTE_SOS_ESC, BYTE_PM_ESC,
                                                 BYTE_APC_ESC};

    logic       clk                = 1'b0;
    logic       rst_n              = 1'b0;
    logic       cfg_valid          = 1'b0;
    logic       cfg_ready;
    logic       cfg_bracketed_mode = 1'b0;
    logic       push               = 1'b0;
    logic       full;
    logic [7:0] data_byte          = 8'h41;
    logic       end_of_text        = 1'b0;
    logic       empty;
    logic       pop                = 1'b0;
    logic [7:0] out_byte;
    logic       run_end;
    logic       paste_end;

    bracketed_paste_control_filter_top dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_bracketed_mode (cfg_bracketed_mode),
        .push               (push),
        .full               (full),
        .data_byte          (data_byte),
        .end_of_text        (end_of_text),
        .empty              (empty),
        .pop                (pop),
        .out_byte           (out_byte),
        .run_end            (run_end),
        .paste_end          (paste_end)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // filter model state
    bit          wrap_mode   = 1'b0;
    bit          paste_open  = 1'b0;
    scan_state_t scan        = SCAN_TEXT;
    bit          bel_ends    = 1'b0;
    logic [7:0]  lead_byte   = 8'h00;
    int unsigned cont_needed = 0;
    logic [7:0]  cont_held [3];
    int unsigned cont_count  = 0;
    logic [7:0]  run_bytes [$];

    res_t        filtered_q [$];
    res_t        want;
    logic [7:0]  paste_bytes [$];

    int send_gap_pct  = 0;
    int pop_stall_pct = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    int err_count       = 0;
    int items_sent      = 0;
    int pastes_sent     = 0;
    int results_checked = 0;
    int mode_writes     = 0;

    function automatic int unsigned utf8_cont_len(logic [7:0] lead);
        if (lead <= UTF8_LEAD2_HI)
            return 1;
        else if (lead <= UTF8_LEAD3_HI)
            return 2;
        return 3;
    endfunction

    function automatic logic [7:0] rand_in(int unsigned lo, int unsigned hi);
        return 8'($urandom_range(hi, lo));
    endfunction

    function automatic void emit(logic [7:0] b);
        if (run_bytes.size() < MAX_RUN)
            run_bytes.push_back(b);
    endfunction

    function automatic void emit_marker(bit closing);
        emit(BYTE_ESC);
        emit(BYTE_LBRACKET);
        emit(BYTE_TWO_CHR);
        emit(BYTE_ZERO_CHR);
        emit(closing ? BYTE_ONE_CHR : BYTE_ZERO_CHR);
        emit(BYTE_TILDE);
    endfunction

    function automatic void clear_lead();
        lead_byte   = 8'h00;
        cont_needed = 0;
        cont_count  = 0;
    endfunction

    // broken UTF-8: lead goes out raw, held bytes are scanned again
    function automatic void release_lead();
        logic [7:0]  saved [3];
        logic [7:0]  lead;
        int unsigned n;
        int          i;
        lead = lead_byte;
        n    = (cont_count > 3) ? 3 : cont_count;
        for (i = 0; i < n; i++)
            saved[i] = cont_held[i];
        clear_lead();
        emit(lead);
        for (i = 0; i < n; i++)
            strip_byte(saved[i]);
    endfunction

    function automatic void strip_text(logic [7:0] b);
        int i;
        if (cont_needed != 0)
        begin
            if ((b & UTF8_CONT_MASK) == UTF8_CONT_TAG)
            begin
                if (cont_count < 3)
                    cont_held[cont_count] = b;
                cont_count = (cont_count + 1) & 3;
                if (cont_count >= cont_needed)
                begin
                    emit(lead_byte);
                    for (i = 0; i < cont_count && i < 3; i++)
                        emit(cont_held[i]);
                    clear_lead();
                end
            end
            else
            begin
                release_lead();
                strip_byte(b);
            end
        end
        else if (b >= UTF8_LEAD_LO && b <= UTF8_LEAD_HI)
        begin
            lead_byte   = b;
            cont_needed = utf8_cont_len(b);
            cont_count  = 0;
        end
        else if (b == BYTE_ESC)
            scan = SCAN_ESC;
        else if (b == BYTE_CSI_C1)
            scan = SCAN_CSI;
        else if (b == BYTE_OSC_C1)
        begin
            scan     = SCAN_STRING;
            bel_ends = 1'b1;
        end
        else if (b inside {BYTE_DCS_C1, BYTE_SOS_C1, BYTE_PM_C1, BYTE_APC_C1})
        begin
            scan     = SCAN_STRING;
            bel_ends = 1'b0;
        end
        else if ((b < BYTE_C0_END && !(b inside {BYTE_TAB, BYTE_LF, BYTE_CR}))
                 || b == BYTE_DEL || (b >= BYTE_C1_LO && b < BYTE_C1_END))
            return;
        else
            emit(b);
    endfunction

    function automatic void strip_byte(logic [7:0] b);
        case (scan)
            SCAN_TEXT:
                strip_text(b);
            SCAN_ESC:
            begin
                if (b == BYTE_LBRACKET)
                    scan = SCAN_CSI;
                else if (b == BYTE_RBRACKET)
                begin
                    scan     = SCAN_STRING;
                    bel_ends = 1'b1;
                end
                else if (b inside {BYTE_DCS_ESC, BYTE_SOS_ESC, BYTE_PM_ESC, BYTE_APC_ESC})
                begin
                    scan     = SCAN_STRING;
                    bel_ends = 1'b0;
                end
                else
                    scan = SCAN_TEXT;
            end
            SCAN_CSI:
                if (b >= BYTE_CSI_LO && b <= BYTE_CSI_HI)
                    scan = SCAN_TEXT;
            SCAN_STRING:
                if ((bel_ends && b == BYTE_BEL) || b == BYTE_ST_C1)
                    scan = SCAN_TEXT;
                else if (b == BYTE_ESC)
                    scan = SCAN_STRING_ESC;
            SCAN_STRING_ESC:
                if (b == BYTE_BACKSLASH)
                    scan = SCAN_TEXT;
                else
                begin
                    scan = SCAN_STRING;
                    strip_byte(b);
                end
            default:
            begin
                scan = SCAN_TEXT;
                strip_text(b);
            end
        endcase
    endfunction

    function automatic void filter_paste_byte(logic [7:0] b, bit eot);
        res_t r;
        int   i;
        run_bytes.delete();
        if (!paste_open && !wrap_mode)
            emit(b);
        else
        begin
            if (!paste_open)
            begin
                emit_marker(1'b0);
                paste_open = 1'b1;
            end
            strip_byte(b);
            if (eot)
            begin
                if (cont_needed != 0)
                    release_lead();
                emit_marker(1'b1);
                scan       = SCAN_TEXT;
                bel_ends   = 1'b0;
                clear_lead();
                paste_open = 1'b0;
            end
        end
        for (i = 0; i < run_bytes.size(); i++)
        begin
            r.out_byte  = run_bytes[i];
            r.run_end   = (i == run_bytes.size() - 1);
            r.paste_end = r.run_end && eot;
            filtered_q.push_back(r);
        end
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("mismatch (result %0d): %s", results_checked, msg);
    endtask

    // result side: pop with random stalls, plus an occasional long hold-off
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_requests != hold_served)
            begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= pop_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (filtered_q.size() == 0)
                report_mismatch($sformatf("unexpected byte %02h", out_byte));
            else
            begin
                want = filtered_q.pop_front();
                if (out_byte !== want.out_byte)
                    report_mismatch($sformatf("out_byte %02h, want %02h",
                                              out_byte, want.out_byte));
                if (run_end !== want.run_end)
                    report_mismatch($sformatf("run_end %b, want %b", run_end, want.run_end));
                if (paste_end !== want.paste_end)
                    report_mismatch($sformatf("paste_end %b, want %b",
                                              paste_end, want.paste_end));
                results_checked++;
            end
        end
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("timeout after %0d cycles, %0d results outstanding",
                 LIMIT_CYCLES, filtered_q.size());
        $display("FAIL bracketed_paste_control_filter_top");
        $finish;
    end

    task automatic send_item(input logic [7:0] b, input bit eot);
        while ($urandom_range(99) < send_gap_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push        <= 1'b1;
        data_byte   <= b;
        end_of_text <= eot;
        do @(posedge clk); while (full);
        filter_paste_byte(b, eot);
        items_sent++;
    endtask

    task automatic send_span(input int first, input int stop, input bit close);
        int i;
        for (i = first; i < stop; i++)
            send_item(paste_bytes[i], close && (i == stop - 1));
        if (close)
            pastes_sent++;
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (filtered_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input bit value);
        wait_idle();
        cfg_valid          <= 1'b1;
        cfg_bracketed_mode <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        wrap_mode = value;
        mode_writes++;
    endtask

    // a paste of random pieces, some broken, now and then cut off inside a sequence
    task automatic build_paste();
        logic [7:0]  lead;
        int unsigned n;
        paste_bytes.delete();
        repeat ($urandom_range(6, 1))
        begin
            case ($urandom_range(11))
                0, 1:
                    repeat ($urandom_range(4, 1))
                        paste_bytes.push_back(rand_in(8'h20, 8'h7E));
                2:
                begin
                    lead = rand_in(UTF8_LEAD_LO, UTF8_LEAD_HI);
                    paste_bytes.push_back(lead);
                    repeat (utf8_cont_len(lead))
                        paste_bytes.push_back(rand_in(8'h80, 8'hBF));
                end
                3:
                begin
                    lead = rand_in(UTF8_LEAD_LO, UTF8_LEAD_HI);
                    n    = utf8_cont_len(lead);
                    paste_bytes.push_back(lead);
                    repeat ($urandom_range(n - 1, 0))
                        paste_bytes.push_back(rand_in(8'h80, 8'hBF));
                    paste_bytes.push_back($urandom_range(1) ? rand_in(8'h01, 8'h7F)
                                                            : rand_in(8'hC0, 8'hFF));
                end
                4, 5:
                begin
                    if ($urandom_range(1))
                    begin
                        paste_bytes.push_back(BYTE_ESC);
                        paste_bytes.push_back(BYTE_LBRACKET);
                    end
                    else
                        paste_bytes.push_back(BYTE_CSI_C1);
                    repeat ($urandom_range(3))
                        paste_bytes.push_back(rand_in(8'h20, 8'h3F));
                    paste_bytes.push_back(rand_in(BYTE_CSI_LO, BYTE_CSI_HI));
                end
                6:
                begin
                    if ($urandom_range(1))
                    begin
                        paste_bytes.push_back(BYTE_ESC);
                        paste_bytes.push_back(BYTE_RBRACKET);
                    end
                    else
                        paste_bytes.push_back(BYTE_OSC_C1);
                    repeat ($urandom_range(3))
                        paste_bytes.push_back(rand_in(8'h20, 8'h7E));
                    case ($urandom_range(2))
                        0: paste_bytes.push_back(BYTE_BEL);
                        1: paste_bytes.push_back(BYTE_ST_C1);
                        default:
                        begin
                            paste_bytes.push_back(BYTE_ESC);
                            paste_bytes.push_back(BYTE_BACKSLASH);
                        end
                    endcase
                end
                7:
                begin
                    if ($urandom_range(1))
                        paste_bytes.push_back(STR_INTRO_C1[$urandom_range(3)]);
                    else
                    begin
                        paste_bytes.push_back(BYTE_ESC);
                        paste_bytes.push_back(STR_INTRO_ESC[$urandom_range(3)]);
                    end
                    repeat ($urandom_range(3))
                        paste_bytes.push_back($urandom_range(3) == 0 ? BYTE_BEL
                                                                     : rand_in(8'h20, 8'h7E));
                    if ($urandom_range(1))
                        paste_bytes.push_back(BYTE_ST_C1);
                    else
                    begin
                        paste_bytes.push_back(BYTE_ESC);
                        paste_bytes.push_back(BYTE_BACKSLASH);
                    end
                end
                8:
                begin
                    paste_bytes.push_back(BYTE_ESC);
                    paste_bytes.push_back(rand_in(8'h20, 8'h7E));
                end
                9:
                    case ($urandom_range(2))
                        0: paste_bytes.push_back(rand_in(8'h01, 8'h1F));
                        1: paste_bytes.push_back(BYTE_DEL);
                        default: paste_bytes.push_back(rand_in(BYTE_C1_LO, 8'h9F));
                    endcase
                10:
                    repeat ($urandom_range(3, 1))
                        paste_bytes.push_back(rand_in(8'h01, 8'hFF));
                default:
                    case ($urandom_range(2))
                        0: paste_bytes.push_back(BYTE_TAB);
                        1: paste_bytes.push_back(BYTE_LF);
                        default: paste_bytes.push_back(BYTE_CR);
                    endcase
            endcase
        end
        if ($urandom_range(3) == 0)
            case ($urandom_range(4))
                0: paste_bytes.push_back(BYTE_ESC);
                1: paste_bytes.push_back(rand_in(UTF8_LEAD_LO, UTF8_LEAD_HI));
                2:
                begin
                    paste_bytes.push_back(BYTE_ESC);
                    paste_bytes.push_back(BYTE_LBRACKET);
                    paste_bytes.push_back(8'h33);
                end
                3:
                begin
                    paste_bytes.push_back(BYTE_OSC_C1);
                    paste_bytes.push_back(8'h61);
                end
                default:
                begin
                    paste_bytes.push_back(BYTE_ESC);
                    paste_bytes.push_back(BYTE_DCS_ESC);
                    paste_bytes.push_back(BYTE_ESC);
                end
            endcase
    endtask

    task automatic test_passthrough();
        write_mode(1'b0);
        paste_bytes = '{8'hFF, BYTE_ESC, 8'h01};
        send_span(0, paste_bytes.size(), 1'b1);
    endtask

    task automatic test_bracketed_basics();
        write_mode(1'b1);
        // single byte paste: both markers in one run
        paste_bytes = '{8'h41};
        send_span(0, 1, 1'b1);
        // CSI, kept TAB, DEL, C1 inside UTF-8, broken lead, lead held at the end
        paste_bytes = '{BYTE_ESC, BYTE_LBRACKET, 8'h6D, BYTE_TAB, BYTE_DEL,
                        8'hC3, BYTE_CSI_C1, 8'hE2, 8'h41, UTF8_LEAD_HI};
        send_span(0, paste_bytes.size(), 1'b1);
        // OSC ended by BEL, DCS where BEL is content, lone ESC at the end
        paste_bytes = '{BYTE_OSC_C1, BYTE_BEL, BYTE_ESC, BYTE_DCS_ESC, BYTE_BEL,
                        BYTE_ST_C1, BYTE_ESC};
        send_span(0, paste_bytes.size(), 1'b1);
    endtask

    task automatic test_mode_change_mid_paste();
        paste_bytes = '{8'h41, 8'h42};
        send_span(0, 1, 1'b0);
        write_mode(1'b0);
        send_span(1, 2, 1'b1);
    endtask

    task automatic test_random_traffic(input int gap_pct, input int stall_pct);
        int start;
        int half;
        send_gap_pct  = gap_pct;
        pop_stall_pct = stall_pct;
        write_mode(1'b1);
        start = items_sent;
        while (items_sent - start < 60)
        begin
            build_paste();
            send_span(0, paste_bytes.size(), 1'b1);
        end
        build_paste();
        paste_bytes.push_back(rand_in(8'h20, 8'h7E));
        half = paste_bytes.size() / 2;
        send_span(0, half, 1'b0);
        write_mode(1'b0);
        send_span(half, paste_bytes.size(), 1'b1);
        repeat (30)
            send_item(rand_in(8'h01, 8'hFF), $urandom_range(7) == 0);
    endtask

    // receiver stops for a long stretch; the sender keeps offering transfers
    task automatic test_backpressure();
        send_gap_pct  = 0;
        pop_stall_pct = 0;
        write_mode(1'b1);
        hold_requests++;
        repeat (5)
        begin
            paste_bytes.delete();
            repeat (8)
                paste_bytes.push_back(rand_in(8'h20, 8'h7E));
            send_span(0, 8, 1'b1);
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_passthrough();
        test_bracketed_basics();
        test_mode_change_mid_paste();
        test_random_traffic(11, 51);
        test_random_traffic(51, 11);
        test_backpressure();
        test_random_traffic(0, 0);

        wait_idle();
        if (filtered_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", filtered_q.size()));

        $display("%0d bytes in %0d pastes, %0d output bytes checked, %0d mode writes",
                 items_sent, pastes_sent, results_checked, mode_writes);
        $display("idle mixes 11/51, 51/11, 0/0 and one %0d-cycle receiver hold-off",
                 HOLD_CYCLES);
        if (err_count == 0)
            $display("PASS bracketed_paste_control_filter_top");
        else
            $display("FAIL bracketed_paste_control_filter_top");
        $finish;
    end

endmodule
